// File: rtl/dtt_pkg.sv
// Types and constants shared by the divergent thread table.
package dtt_pkg;

    localparam int SLOT_W   = 5;
    localparam int TAG_W    = 6;
    localparam int THREAD_W = 6;
    localparam int WARP_W   = 7;
    localparam int PC_W     = 32;

    // Largest slot count that a slot index can reach
    localparam int SLOT_SPAN = 32;

    localparam logic [TAG_W-1:0]    TAG_NONE    = '1;
    localparam logic [THREAD_W-1:0] THREAD_NONE = '1;
    localparam logic [WARP_W-1:0]   WARP_NONE   = '1;
    localparam logic [PC_W-1:0]     PC_NONE     = '1;

    typedef enum logic [2:0] {
        REQ_SET     = 3'd0,
        REQ_CLEAR   = 3'd1,
        REQ_INVAL   = 3'd2,
        REQ_READ    = 3'd3,
        REQ_FREE    = 3'd4,
        REQ_WARP    = 3'd5,
        REQ_REVERSE = 3'd6
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [SLOT_W-1:0]   slot;
        logic [THREAD_W-1:0] thread_id;
        logic [WARP_W-1:0]   warp_id;
        logic [PC_W-1:0]     reconv_pc;
    } dtt_req_t;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   found_slot;
        logic                slot_valid;
        logic [TAG_W-1:0]    slot_tag;
        logic [THREAD_W-1:0] thread_out;
        logic [WARP_W-1:0]   warp_out;
        logic [PC_W-1:0]     pc_out;
    } dtt_rsp_t;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [WARP_W-1:0]   warp;
        logic [PC_W-1:0]     pc;
    } mem_word_t;

endpackage

// File: rtl/dtt_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface dtt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/divergent_thread_table.sv
// Divergent thread table: slot store with set/clear/read and sequential searches.
//
//  channel | dir | payload    | transaction
//  --------+-----+------------+-----------------------------
//  req     | in  | dtt_req_t  | req.valid && req.ready
//  rsp     | out | dtt_rsp_t  | rsp.valid && rsp.ready
//
// One request at a time: set, clear, invalidate, bad codes and out-of-range reads go from
// DISPATCH to DONE, a read via READ, a search via SCAN until a match or min(ENTRIES, 32)
// slots, one slot per cycle from the field memory into one shared compare unit.
// Reset clears the valid and written bits at once; no clearing pass.
// A stalled result holds in the output register; the next request is still taken and its
// result waits in DONE, req low, until the register frees.
module divergent_thread_table #(
    parameter int ENTRIES = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    dtt_stream_if.sink   req,
    dtt_stream_if.source rsp
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SCAN_N = (ENTRIES < dtt_pkg::SLOT_SPAN) ? ENTRIES : dtt_pkg::SLOT_SPAN;
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);

    dtt_pkg::state_t    state_reg, state_next;
    dtt_pkg::dtt_req_t  op_reg, op_next;
    dtt_pkg::dtt_rsp_t  res_reg, res_next;
    dtt_pkg::dtt_rsp_t  out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] init_reg, init_next;

    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic               chk_live_reg, chk_live_next;
    logic               chk_valid_reg;
    logic               chk_init_reg;

    dtt_pkg::mem_word_t mem [ENTRIES];
    dtt_pkg::mem_word_t mem_rd_reg;
    dtt_pkg::mem_word_t mem_wdata;
    logic               mem_we;
    logic [IDX_W-1:0]   rd_addr;

    logic [31:0]        slot_ext;
    logic [31:0]        chk_idx_ext;
    logic [IDX_W-1:0]   op_idx;
    logic               op_in_range;

    logic [dtt_pkg::THREAD_W-1:0] eff_thread;
    logic [dtt_pkg::WARP_W-1:0]   eff_warp;
    logic [dtt_pkg::PC_W-1:0]     eff_pc;
    logic                         warp_eq;
    logic                         thread_eq;
    logic                         match;

    assign slot_ext    = 32'(op_reg.slot);
    assign op_idx      = slot_ext[IDX_W-1:0];
    assign op_in_range = slot_ext < 32'(ENTRIES);
    assign chk_idx_ext = 32'(chk_idx_reg);

    // Unwritten or cleared slots read back as all ones
    assign eff_thread = chk_init_reg ? mem_rd_reg.thread : dtt_pkg::THREAD_NONE;
    assign eff_warp   = chk_init_reg ? mem_rd_reg.warp   : dtt_pkg::WARP_NONE;
    assign eff_pc     = chk_init_reg ? mem_rd_reg.pc     : dtt_pkg::PC_NONE;

    // Shared compare unit
    assign warp_eq   = eff_warp == op_reg.warp_id;
    assign thread_eq = eff_thread == op_reg.thread_id;

    always_comb
    begin
        case (dtt_pkg::req_type_t'(op_reg.req_type))
            dtt_pkg::REQ_FREE:    match = !chk_valid_reg;
            dtt_pkg::REQ_WARP:    match = chk_valid_reg && warp_eq;
            dtt_pkg::REQ_REVERSE: match = warp_eq && thread_eq;
            default:              match = 1'b0;
        endcase
    end

    assign req.ready = (state_reg == dtt_pkg::ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        valid_next     = valid_reg;
        init_next      = init_reg;
        scan_idx_next  = scan_idx_reg;
        chk_live_next  = 1'b0;
        rd_addr        = scan_idx_reg;
        mem_we         = 1'b0;
        mem_wdata.thread = op_reg.thread_id;
        mem_wdata.warp   = op_reg.warp_id;
        mem_wdata.pc     = op_reg.reconv_pc;

        case (state_reg)
            dtt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.data;
                    state_next = dtt_pkg::ST_DISPATCH;
                end
            end

            dtt_pkg::ST_DISPATCH:
            begin
                res_next     = '0;
                res_next.hit = 1'b1;
                rd_addr      = op_idx;
                state_next   = dtt_pkg::ST_DONE;
                case (dtt_pkg::req_type_t'(op_reg.req_type))
                    dtt_pkg::REQ_SET:
                    begin
                        if (op_in_range)
                        begin
                            mem_we             = 1'b1;
                            valid_next[op_idx] = 1'b1;
                            init_next[op_idx]  = 1'b1;
                        end
                    end
                    dtt_pkg::REQ_CLEAR:
                    begin
                        if (op_in_range)
                        begin
                            valid_next[op_idx] = 1'b0;
                            init_next[op_idx]  = 1'b0;
                        end
                    end
                    dtt_pkg::REQ_INVAL:
                    begin
                        if (op_in_range)
                            valid_next[op_idx] = 1'b0;
                    end
                    dtt_pkg::REQ_READ:
                    begin
                        if (op_in_range)
                            state_next = dtt_pkg::ST_READ;
                        else
                            res_next.hit = 1'b0;
                    end
                    dtt_pkg::REQ_FREE, dtt_pkg::REQ_WARP, dtt_pkg::REQ_REVERSE:
                    begin
                        scan_idx_next = '0;
                        state_next    = dtt_pkg::ST_SCAN;
                    end
                    default:
                        res_next.hit = 1'b0;
                endcase
            end

            dtt_pkg::ST_READ:
            begin
                res_next            = '0;
                res_next.hit        = 1'b1;
                res_next.slot_valid = chk_valid_reg;
                res_next.slot_tag   = chk_init_reg ? chk_idx_ext[dtt_pkg::TAG_W-1:0]
                                                   : dtt_pkg::TAG_NONE;
                res_next.thread_out = eff_thread;
                res_next.warp_out   = eff_warp;
                res_next.pc_out     = eff_pc;
                state_next          = dtt_pkg::ST_DONE;
            end

            dtt_pkg::ST_SCAN:
            begin
                // Issue one slot per cycle; compare the slot issued last cycle
                chk_live_next = 1'b1;
                if (scan_idx_reg != SCAN_LAST)
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (chk_live_reg)
                begin
                    if (match)
                    begin
                        res_next     = '0;
                        res_next.hit = 1'b1;
                        if (dtt_pkg::req_type_t'(op_reg.req_type) == dtt_pkg::REQ_WARP)
                            res_next.thread_out = eff_thread;
                        else
                            res_next.found_slot = chk_idx_ext[dtt_pkg::SLOT_W-1:0];
                        chk_live_next = 1'b0;
                        state_next    = dtt_pkg::ST_DONE;
                    end
                    else if (chk_idx_reg == SCAN_LAST)
                    begin
                        res_next = '0;
                        if (dtt_pkg::req_type_t'(op_reg.req_type) == dtt_pkg::REQ_WARP)
                            res_next.thread_out = dtt_pkg::THREAD_NONE;
                        chk_live_next = 1'b0;
                        state_next    = dtt_pkg::ST_DONE;
                    end
                end
            end

            dtt_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = dtt_pkg::ST_IDLE;
                end
            end

            default:
                state_next = dtt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            init_reg      <= '0;
            chk_live_reg  <= 1'b0;
            scan_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            init_reg      <= init_next;
            chk_live_reg  <= chk_live_next;
            scan_idx_reg  <= scan_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
        chk_idx_reg   <= rd_addr;
        chk_valid_reg <= valid_reg[rd_addr];
        chk_init_reg  <= init_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[op_idx] <= mem_wdata;
        mem_rd_reg <= mem[rd_addr];
    end

endmodule
